// ===== src/tpp_pkg.sv =====
`timescale 1ns / 1ps

package tpp_pkg;

    localparam int DEF_SCREEN_LENGTH  = 800;
    localparam int DEF_SCREEN_WIDTH   = 480;
    localparam int DEF_HALF_BIT_TICKS = 2;
    localparam int DEF_SAMPLE_BITS    = 12;

    localparam int RAW_W   = 12;
    localparam int TIMER_W = 16;
    localparam int CMD_W   = 8;
    localparam int TX_W    = 10;
    localparam int TY_W    = 9;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 32;
    localparam int ADDR_W  = 5;

    localparam logic [RAW_W-1:0] IGNORE_RAW_Y = 12'd1023;

    // protocol phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WAIT  = 3'd1;
    localparam logic [2:0] PH_CMDX  = 3'd2;
    localparam logic [2:0] PH_SMPX  = 3'd3;
    localparam logic [2:0] PH_TAILX = 3'd4;
    localparam logic [2:0] PH_CMDY  = 3'd5;
    localparam logic [2:0] PH_SMPY  = 3'd6;
    localparam logic [2:0] PH_TAILY = 3'd7;

    // register indexes
    localparam logic [2:0] REG_CMD_X  = 3'd0;
    localparam logic [2:0] REG_CMD_Y  = 3'd1;
    localparam logic [2:0] REG_FIRST  = 3'd2;
    localparam logic [2:0] REG_POLL   = 3'd3;
    localparam logic [2:0] REG_LEFT   = 3'd4;
    localparam logic [2:0] REG_RIGHT  = 3'd5;
    localparam logic [2:0] REG_TOP    = 3'd6;
    localparam logic [2:0] REG_BOTTOM = 3'd7;

    typedef struct packed {
        logic start;
    } tpp_dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tpp_dp_sts_t;

    function automatic logic [TIMER_W-1:0] load_timer(input logic [TIMER_W-1:0] v);
        load_timer = (v == '0) ? TIMER_W'(1) : v;
    endfunction

endpackage

// ===== src/tpp_scale.sv =====
`timescale 1ns / 1ps

module tpp_scale #(
    parameter int SCREEN_LENGTH = tpp_pkg::DEF_SCREEN_LENGTH,
    parameter int SCREEN_WIDTH  = tpp_pkg::DEF_SCREEN_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tpp_pkg::tpp_dp_cmd_t         cmd,
    output tpp_pkg::tpp_dp_sts_t         sts,
    input  logic [tpp_pkg::RAW_W-1:0]    raw_x,
    input  logic [tpp_pkg::RAW_W-1:0]    raw_y,
    input  logic [tpp_pkg::RAW_W-1:0]    cal_left,
    input  logic [tpp_pkg::RAW_W-1:0]    cal_right,
    input  logic [tpp_pkg::RAW_W-1:0]    cal_top,
    input  logic [tpp_pkg::RAW_W-1:0]    cal_bottom,
    output logic [tpp_pkg::TX_W-1:0]     touch_x,
    output logic [tpp_pkg::TY_W-1:0]     touch_y
);
    import tpp_pkg::*;

    localparam int PROD_W = 2 * RAW_W;
    localparam int STEP_W = $clog2(PROD_W + 2);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W + 1);
    localparam int SQ_W = PROD_W + 3;
    localparam logic [RAW_W-1:0] LEN_C = RAW_W'(SCREEN_LENGTH);
    localparam logic [RAW_W-1:0] WID_C = RAW_W'(SCREEN_WIDTH);

    logic                run_reg;
    logic                axis_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [RAW_W:0]      rem_reg;
    logic [PROD_W-1:0]   quo_reg;
    logic [RAW_W-1:0]    den_reg;
    logic                neg_reg;
    logic                zero_reg;
    logic                done_reg;
    logic [RAW_W-1:0]    tx_reg;
    logic [RAW_W-1:0]    ty_reg;

    logic signed [RAW_W:0] num_s;
    logic signed [RAW_W:0] den_s;
    logic [RAW_W-1:0]      num_mag;
    logic [RAW_W-1:0]      den_mag;
    logic [RAW_W-1:0]      mul_c;
    logic [RAW_W:0]        r2;
    logic [PROD_W-1:0]     q_mag;
    logic signed [SQ_W-1:0] q_s;
    logic signed [SQ_W-1:0] v_s;
    logic [RAW_W-1:0]      hi_c;
    logic [RAW_W-1:0]      clamped;

    always_comb
    begin
        if (axis_reg)
        begin
            num_s = $signed({1'b0, raw_x}) - $signed({1'b0, cal_top});
            den_s = $signed({1'b0, cal_bottom}) - $signed({1'b0, cal_top});
            mul_c = WID_C;
        end
        else
        begin
            num_s = $signed({1'b0, cal_left}) - $signed({1'b0, raw_y});
            den_s = $signed({1'b0, cal_left}) - $signed({1'b0, cal_right});
            mul_c = LEN_C;
        end
        num_mag = num_s[RAW_W] ? RAW_W'(-num_s) : num_s[RAW_W-1:0];
        den_mag = den_s[RAW_W] ? RAW_W'(-den_s) : den_s[RAW_W-1:0];
        r2 = {rem_reg[RAW_W-1:0], quo_reg[PROD_W-1]};
        q_mag = zero_reg ? '0 : quo_reg;
        q_s = neg_reg ? -$signed({3'b000, q_mag}) : $signed({3'b000, q_mag});
        if (axis_reg)
        begin
            v_s  = q_s;
            hi_c = WID_C;
        end
        else
        begin
            v_s  = $signed({{(SQ_W-RAW_W){1'b0}}, LEN_C}) - q_s;
            hi_c = LEN_C;
        end
        if (v_s < 0)
            clamped = '0;
        else if (v_s > $signed({{(SQ_W-RAW_W){1'b0}}, hi_c}))
            clamped = hi_c;
        else
            clamped = v_s[RAW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            axis_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                run_reg  <= 1'b1;
                axis_reg <= 1'b0;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    step_reg <= '0;
                    axis_reg <= ~axis_reg;
                    if (axis_reg)
                    begin
                        run_reg  <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
                else
                    step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            if (step_reg == '0)
            begin
                quo_reg  <= mul_c * num_mag;
                rem_reg  <= '0;
                den_reg  <= den_mag;
                neg_reg  <= num_s[RAW_W] ^ den_s[RAW_W];
                zero_reg <= (den_mag == '0);
            end
            else if (step_reg == LAST_STEP)
            begin
                if (axis_reg)
                    ty_reg <= clamped;
                else
                    tx_reg <= clamped;
            end
            else if (r2 >= {1'b0, den_reg})
            begin
                rem_reg <= r2 - {1'b0, den_reg};
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= r2;
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
            end
        end
    end

    assign sts.busy = run_reg;
    assign sts.done = done_reg;
    assign touch_x  = tx_reg[TX_W-1:0];
    assign touch_y  = ty_reg[TY_W-1:0];

endmodule

// ===== src/tpp_ctrl.sv =====
`timescale 1ns / 1ps

module tpp_ctrl #(
    parameter int HALF_BIT_TICKS = tpp_pkg::DEF_HALF_BIT_TICKS,
    parameter int SAMPLE_BITS    = tpp_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tpp_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tpp_pkg::OUT_W-1:0]     m_tdata,
    input  logic [tpp_pkg::CMD_W-1:0]     cmd_x_channel,
    input  logic [tpp_pkg::CMD_W-1:0]     cmd_y_channel,
    input  logic [tpp_pkg::TIMER_W-1:0]   first_delay_ticks,
    input  logic [tpp_pkg::TIMER_W-1:0]   poll_period_ticks,
    output tpp_pkg::tpp_dp_cmd_t          dp_cmd,
    input  tpp_pkg::tpp_dp_sts_t          dp_sts,
    input  logic [tpp_pkg::TX_W-1:0]      touch_x,
    input  logic [tpp_pkg::TY_W-1:0]      touch_y,
    output logic [tpp_pkg::RAW_W-1:0]     raw_x,
    output logic [tpp_pkg::RAW_W-1:0]     raw_y
);
    import tpp_pkg::*;

    localparam logic [TIMER_W-1:0] HALF_T  = TIMER_W'(HALF_BIT_TICKS);
    localparam logic [TIMER_W-1:0] TWO_H_T = TIMER_W'(2 * HALF_BIT_TICKS);
    localparam logic [4:0]         NB_CMD  = 5'd8;
    localparam logic [4:0]         NB_SMP  = 5'(SAMPLE_BITS);
    localparam logic [4:0]         NB_TAIL = 5'd3;

    localparam logic CS_RUN  = 1'b0;
    localparam logic CS_CALC = 1'b1;

    logic                 state_reg;
    logic [2:0]           phase_reg, phase_next;
    logic [TIMER_W-1:0]   delay_reg, delay_next;
    logic [4:0]           bit_reg, bit_next;
    logic [RAW_W-1:0]     shift_reg, shift_next;
    logic [RAW_W-1:0]     raw_x_reg, raw_x_next;
    logic [RAW_W-1:0]     raw_y_reg, raw_y_next;
    logic                 flag_reg, flag_next;
    logic                 last_reg, last_next;
    logic                 mval_reg;
    logic [OUT_W-1:0]     mdata_reg;
    logic                 pend_down_reg;

    logic                 pen, sdi, accept;
    logic                 sclk, cs, sout, down_ev, up_ev, calc;
    logic [4:0]           nbits, bc;
    logic [CMD_W-1:0]     cmd;
    logic [TIMER_W-1:0]   t1;
    logic [OUT_W-1:0]     beat;

    assign pen      = s_tdata[0];
    assign sdi      = s_tdata[1];
    assign s_tready = (state_reg == CS_RUN) && !dp_sts.busy && (!mval_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        phase_next = phase_reg;
        delay_next = delay_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        raw_x_next = raw_x_reg;
        raw_y_next = raw_y_reg;
        flag_next  = flag_reg;
        sclk = 1'b0;
        cs = 1'b0;
        sout = 1'b0;
        down_ev = 1'b0;
        up_ev = 1'b0;
        calc = 1'b0;
        nbits = '0;
        bc = '0;
        t1 = '0;
        cmd = (phase_reg == PH_CMDX) ? cmd_x_channel : cmd_y_channel;
        case (phase_reg)
            PH_WAIT:
            begin
                if (delay_reg <= TIMER_W'(1))
                begin
                    if (flag_reg && pen)
                    begin
                        up_ev      = 1'b1;
                        flag_next  = 1'b0;
                        phase_next = PH_IDLE;
                        delay_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_CMDX;
                        bit_next   = '0;
                        delay_next = '0;
                        shift_next = '0;
                    end
                end
                else
                    delay_next = delay_reg - TIMER_W'(1);
            end
            PH_CMDX, PH_CMDY:
            begin
                cs    = 1'b1;
                sout  = cmd[3'd7 - bit_reg[2:0]];
                sclk  = (delay_reg >= HALF_T);
                nbits = NB_CMD;
            end
            PH_SMPX, PH_SMPY:
            begin
                cs   = 1'b1;
                sclk = (delay_reg < HALF_T);
                if (delay_reg == HALF_T - TIMER_W'(1))
                    shift_next = {shift_reg[RAW_W-2:0], sdi};
                nbits = NB_SMP;
            end
            PH_TAILX, PH_TAILY:
            begin
                cs    = 1'b1;
                sclk  = (delay_reg < HALF_T);
                nbits = NB_TAIL;
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (last_reg && !pen)
                begin
                    delay_next = load_timer(first_delay_ticks);
                    phase_next = PH_WAIT;
                end
            end
        endcase

        if (nbits != '0)
        begin
            t1 = delay_reg + TIMER_W'(1);
            delay_next = t1;
            if (t1 >= TWO_H_T)
            begin
                delay_next = '0;
                bc = bit_reg + 5'd1;
                bit_next = bc;
                if (bc >= nbits)
                begin
                    bit_next = '0;
                    if (phase_reg == PH_SMPX)
                        raw_x_next = shift_next;
                    if (phase_reg == PH_SMPY)
                        raw_y_next = shift_next;
                    if (phase_reg == PH_SMPX || phase_reg == PH_SMPY)
                        shift_next = '0;
                    if (phase_reg == PH_TAILY)
                    begin
                        if (raw_x_reg == '0 && raw_y_reg == IGNORE_RAW_Y)
                            flag_next = 1'b1;
                        else
                        begin
                            down_ev   = !flag_reg;
                            flag_next = 1'b1;
                            calc      = 1'b1;
                        end
                        delay_next = load_timer(poll_period_ticks);
                        phase_next = PH_WAIT;
                    end
                    else
                        phase_next = phase_reg + 3'd1;
                end
            end
        end
        last_next = pen;
        beat = {7'd0, 9'd0, 10'd0, 1'b0, up_ev, down_ev, sout, cs, sclk};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_RUN;
            phase_reg     <= PH_IDLE;
            delay_reg     <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            raw_x_reg     <= '0;
            raw_y_reg     <= '0;
            flag_reg      <= 1'b0;
            last_reg      <= 1'b1;
            mval_reg      <= 1'b0;
            pend_down_reg <= 1'b0;
        end
        else
        begin
            if (accept && !calc)
                mval_reg <= 1'b1;
            else if (state_reg == CS_CALC && dp_sts.done)
                mval_reg <= 1'b1;
            else if (mval_reg && m_tready)
                mval_reg <= 1'b0;
            if (accept)
            begin
                phase_reg <= phase_next;
                delay_reg <= delay_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                raw_x_reg <= raw_x_next;
                raw_y_reg <= raw_y_next;
                flag_reg  <= flag_next;
                last_reg  <= last_next;
                if (calc)
                begin
                    state_reg     <= CS_CALC;
                    pend_down_reg <= down_ev;
                end
            end
            if (state_reg == CS_CALC && dp_sts.done)
                state_reg <= CS_RUN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !calc)
            mdata_reg <= beat;
        else if (state_reg == CS_CALC && dp_sts.done)
            mdata_reg <= {7'd0, touch_y, touch_x, 1'b1, 1'b0, pend_down_reg,
                          1'b0, 1'b1, 1'b0};
    end

    assign dp_cmd.start = accept && calc;
    assign m_tvalid     = mval_reg;
    assign m_tdata      = mdata_reg;
    assign raw_x        = raw_x_reg;
    assign raw_y        = raw_y_reg;

endmodule

// ===== src/touchscreen_pen_poll_controller_top.sv =====
`timescale 1ns / 1ps

// channel   dir   handshake                 payload
// s_        in    s_tvalid / s_tready       s_tdata  pen_line, serial_in
// m_        out   m_tvalid / m_tready       m_tdata  pins, events, touch_x, touch_y
// apb       in    psel / penable / pready   paddr, pwdata, prdata
//
// one tick per cycle while the result register drains
// the last tick of the y read starts the scaling unit, unless the sample is the
// ignore pattern: a multiply and a restoring divide per axis, then the result
// is loaded into the beat; the next tick waits until scaling is done
// reset clears the protocol state and loads the register defaults
// s_tready falls while scaling runs and while the output register is full and not taken

module touchscreen_pen_poll_controller_top #(
    parameter int SCREEN_LENGTH  = tpp_pkg::DEF_SCREEN_LENGTH,
    parameter int SCREEN_WIDTH   = tpp_pkg::DEF_SCREEN_WIDTH,
    parameter int HALF_BIT_TICKS = tpp_pkg::DEF_HALF_BIT_TICKS,
    parameter int SAMPLE_BITS    = tpp_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tpp_pkg::IN_W-1:0]      s_tdata,   // pen_line, serial_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // serial_clock, chip_select, serial_out, pen_down_event, pen_up_event,
    // coord_valid, touch_x[9:0], touch_y[8:0]
    output logic [tpp_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpp_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tpp_pkg::*;

    logic [CMD_W-1:0]   cmd_x_reg, cmd_y_reg;
    logic [TIMER_W-1:0] first_reg, poll_reg;
    logic [RAW_W-1:0]   left_reg, right_reg, top_reg, bottom_reg;
    logic [2:0]         reg_idx;
    logic               wr;

    tpp_dp_cmd_t        dp_cmd;
    tpp_dp_sts_t        dp_sts;
    logic [TX_W-1:0]    tx;
    logic [TY_W-1:0]    ty;
    logic [RAW_W-1:0]   raw_x, raw_y;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr      = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_x_reg  <= 8'd208;
            cmd_y_reg  <= 8'd144;
            first_reg  <= 16'd100;
            poll_reg   <= 16'd500;
            left_reg   <= 12'd1000;
            right_reg  <= 12'd50;
            top_reg    <= 12'd50;
            bottom_reg <= 12'd960;
        end
        else if (wr)
        begin
            case (reg_idx)
                REG_CMD_X:  cmd_x_reg  <= pwdata[7:0];
                REG_CMD_Y:  cmd_y_reg  <= pwdata[7:0];
                REG_FIRST:  first_reg  <= pwdata[15:0];
                REG_POLL:   poll_reg   <= pwdata[15:0];
                REG_LEFT:   left_reg   <= pwdata[11:0];
                REG_RIGHT:  right_reg  <= pwdata[11:0];
                REG_TOP:    top_reg    <= pwdata[11:0];
                REG_BOTTOM: bottom_reg <= pwdata[11:0];
                default:    cmd_x_reg  <= cmd_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CMD_X:  prdata = {24'd0, cmd_x_reg};
            REG_CMD_Y:  prdata = {24'd0, cmd_y_reg};
            REG_FIRST:  prdata = {16'd0, first_reg};
            REG_POLL:   prdata = {16'd0, poll_reg};
            REG_LEFT:   prdata = {20'd0, left_reg};
            REG_RIGHT:  prdata = {20'd0, right_reg};
            REG_TOP:    prdata = {20'd0, top_reg};
            REG_BOTTOM: prdata = {20'd0, bottom_reg};
            default:    prdata = '0;
        endcase
    end

    tpp_ctrl #(
        .HALF_BIT_TICKS (HALF_BIT_TICKS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .cmd_x_channel     (cmd_x_reg),
        .cmd_y_channel     (cmd_y_reg),
        .first_delay_ticks (first_reg),
        .poll_period_ticks (poll_reg),
        .dp_cmd            (dp_cmd),
        .dp_sts            (dp_sts),
        .touch_x           (tx),
        .touch_y           (ty),
        .raw_x             (raw_x),
        .raw_y             (raw_y)
    );

    tpp_scale #(
        .SCREEN_LENGTH (SCREEN_LENGTH),
        .SCREEN_WIDTH  (SCREEN_WIDTH)
    ) u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .sts        (dp_sts),
        .raw_x      (raw_x),
        .raw_y      (raw_y),
        .cal_left   (left_reg),
        .cal_right  (right_reg),
        .cal_top    (top_reg),
        .cal_bottom (bottom_reg),
        .touch_x    (tx),
        .touch_y    (ty)
    );

    // coordinates only come with chip select high and clock low
    a_coord_cs: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5] |-> m_tdata[1] && !m_tdata[0])
        else $error("coordinate beat outside a transfer");

    // serial clock only toggles inside a transfer
    a_sclk_cs: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("serial clock without chip select");

    // pen up and pen down never in one beat
    a_events: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
        else $error("pen up and pen down together");

    // no new tick taken while the scaling unit runs
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dp_sts.busy |-> !s_tready)
        else $error("tick accepted during scaling");

endmodule
